// File: sv/bank_mapper_with_line_irq_core_assert.svh
// Assertion macros for the bank mapper RTL.
`ifndef BANK_MAPPER_WITH_LINE_IRQ_CORE_ASSERT_SVH
`define BANK_MAPPER_WITH_LINE_IRQ_CORE_ASSERT_SVH
`ifndef SYNTH
// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define BM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bank mapper assertion failed");
// Checked on every rising edge of clk_i, reset included.
`define BM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("bank mapper assertion failed");
`else
`define BM_ASSERT(lbl, prop)
`define BM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/bmlirq_pkg.sv
// Types and constants of the bank mapper with line interrupt counter.
package bmlirq_pkg;

  localparam int LINE_CYCLES_DEF = 114;

  // Input beat kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Address decode.
  localparam logic [15:0] ADDR_MASK   = 16'hF003;
  localparam logic [15:0] ADDR_PRG16  = 16'h8000;
  localparam logic [15:0] ADDR_PRG8   = 16'hC000;
  localparam logic [15:0] ADDR_CHR_LO = 16'hD000;
  localparam logic [15:0] ADDR_CHR_HI = 16'hE000;
  localparam logic [15:0] ADDR_MIRROR = 16'hB003;
  localparam logic [15:0] ADDR_LATCH  = 16'hF000;
  localparam logic [15:0] ADDR_CTRL   = 16'hF001;
  localparam logic [15:0] ADDR_ACK    = 16'hF002;

  // Mapping targets.
  localparam logic [3:0] TGT_PRG16  = 4'd0;
  localparam logic [3:0] TGT_PRG8   = 4'd1;
  localparam logic [3:0] TGT_CHR_LO = 4'd2;
  localparam logic [3:0] TGT_CHR_HI = 4'd6;
  localparam logic [3:0] TGT_MIRROR = 4'd10;

  // Mirroring write codes (low nibble) and the reported modes.
  localparam logic [3:0] MIRW_A = 4'h0;
  localparam logic [3:0] MIRW_B = 4'h4;
  localparam logic [3:0] MIRW_C = 4'h8;
  localparam logic [3:0] MIRW_D = 4'hC;
  localparam logic [7:0] MIR_TWO_H   = 8'd0;
  localparam logic [7:0] MIR_TWO_V   = 8'd1;
  localparam logic [7:0] MIR_ONE_PG0 = 8'd2;
  localparam logic [7:0] MIR_ONE_PG1 = 8'd3;

  localparam logic [1:0] FIRES_MAX = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] target;
    logic [7:0] value;
  } map_result_t;

  typedef struct packed {
    logic       latch_we;
    logic       ctrl_we;
    logic       ack_we;
    logic [7:0] data;
  } irq_cmd_t;

  typedef struct packed {
    logic       enabled;
    logic       done;
    logic [1:0] fires;
  } line_status_t;

endpackage

// File: sv/bmlirq_decode.sv
// Bus write decoder: address swap, bank and mirroring reports, interrupt commands.
module bmlirq_decode
  import bmlirq_pkg::*;
(
  input  logic        wr_i,
  input  logic        swap_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output map_result_t map_o,
  output irq_cmd_t    cmd_o
);

  logic [15:0] addr_sw;
  logic [15:0] sel;

  always_comb begin
    addr_sw = swap_i ? {address_i[15:2], address_i[0], address_i[1]} : address_i;
    sel     = addr_sw & ADDR_MASK;

    map_o        = '0;
    cmd_o        = '0;
    cmd_o.data   = data_i;

    case (sel)
      ADDR_PRG16: begin
        map_o = '{valid: wr_i, target: TGT_PRG16, value: data_i};
      end
      ADDR_PRG8: begin
        map_o = '{valid: wr_i, target: TGT_PRG8, value: data_i};
      end
      ADDR_CHR_LO, ADDR_CHR_LO | 16'd1, ADDR_CHR_LO | 16'd2, ADDR_CHR_LO | 16'd3: begin
        map_o = '{valid: wr_i, target: TGT_CHR_LO + {2'b00, sel[1:0]}, value: data_i};
      end
      ADDR_CHR_HI, ADDR_CHR_HI | 16'd1, ADDR_CHR_HI | 16'd2, ADDR_CHR_HI | 16'd3: begin
        map_o = '{valid: wr_i, target: TGT_CHR_HI + {2'b00, sel[1:0]}, value: data_i};
      end
      ADDR_MIRROR: begin
        case (data_i[3:0])
          MIRW_A:  map_o = '{valid: wr_i, target: TGT_MIRROR, value: MIR_TWO_V};
          MIRW_B:  map_o = '{valid: wr_i, target: TGT_MIRROR, value: MIR_TWO_H};
          MIRW_C:  map_o = '{valid: wr_i, target: TGT_MIRROR, value: MIR_ONE_PG0};
          MIRW_D:  map_o = '{valid: wr_i, target: TGT_MIRROR, value: MIR_ONE_PG1};
          default: map_o = '0;
        endcase
      end
      ADDR_LATCH: cmd_o.latch_we = wr_i;
      ADDR_CTRL:  cmd_o.ctrl_we  = wr_i;
      ADDR_ACK:   cmd_o.ack_we   = wr_i;
      default:    map_o = '0;
    endcase

    // Fields of a write that maps nothing stay zero; without a write, all mapping fields are cleared.
    if (!wr_i) begin
      map_o = '0;
    end
  end

endmodule

// File: sv/bmlirq_line_unit.sv
// Interrupt registers and the iterative line counter (one line per cycle).
`include "bank_mapper_with_line_irq_core_assert.svh"
module bmlirq_line_unit
  import bmlirq_pkg::*;
#(
  parameter int LINE_CYCLES = LINE_CYCLES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  irq_cmd_t     cmd_i,
  input  logic         start_i,
  input  logic [7:0]   cycles_i,
  input  logic         take_i,
  output line_status_t status_o
);

  localparam logic [8:0] LineCyc = 9'(LINE_CYCLES);

  logic [6:0] prescaler_q, prescaler_d;
  logic [7:0] counter_q, counter_d;
  logic [7:0] latch_q, latch_d;
  logic       en_q, en_d;
  logic       eaa_q, eaa_d;
  logic [8:0] total_q, total_d;
  logic [1:0] fires_q, fires_d;
  logic       busy_q, busy_d;
  logic       line_due;
  logic       finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q <= '0;
      counter_q   <= '0;
      latch_q     <= '0;
      en_q        <= 1'b0;
      eaa_q       <= 1'b0;
      busy_q      <= 1'b0;
      fires_q     <= '0;
      total_q     <= '0;
    end else begin
      prescaler_q <= prescaler_d;
      counter_q   <= counter_d;
      latch_q     <= latch_d;
      en_q        <= en_d;
      eaa_q       <= eaa_d;
      busy_q      <= busy_d;
      fires_q     <= fires_d;
      total_q     <= total_d;
    end
  end

  always_comb begin
    line_due    = total_q >= LineCyc;
    finish      = busy_q && !line_due && take_i;
    prescaler_d = prescaler_q;
    counter_d   = counter_q;
    latch_d     = latch_q;
    en_d        = en_q;
    eaa_d       = eaa_q;
    busy_d      = busy_q;
    fires_d     = fires_q;
    total_d     = total_q;

    if (cmd_i.latch_we) begin
      latch_d = cmd_i.data;
    end
    if (cmd_i.ctrl_we) begin
      en_d  = cmd_i.data[1];
      eaa_d = cmd_i.data[0];
      if (cmd_i.data[1]) begin
        counter_d = latch_q;
      end
    end
    if (cmd_i.ack_we) begin
      en_d = eaa_q;
    end

    if (start_i) begin
      busy_d  = 1'b1;
      fires_d = '0;
      total_d = {2'b00, prescaler_q} + {1'b0, cycles_i};
    end else if (busy_q) begin
      if (line_due) begin
        // One elapsed line per cycle through the shared subtract and compare.
        total_d = total_q - LineCyc;
        if (counter_q == 8'hFF) begin
          counter_d = latch_q;
          if (fires_q != FIRES_MAX) begin
            fires_d = fires_q + 2'd1;
          end
        end else begin
          counter_d = counter_q + 8'd1;
        end
      end else if (finish) begin
        prescaler_d = total_q[6:0];
        busy_d      = 1'b0;
      end
    end
  end

  assign status_o = '{enabled: en_q, done: busy_q && !line_due, fires: fires_q};

  `BM_ASSERT(a_prescaler_range, {2'b00, prescaler_q} < LineCyc)
  `BM_ASSERT(a_start_when_free, start_i |-> !busy_q)
  `BM_ASSERT(a_fires_grow, (busy_q && !finish) |=> (busy_q && fires_q >= $past(fires_q)))
  `BM_ASSERT(a_no_cmd_while_busy,
             busy_q |-> !(cmd_i.latch_we || cmd_i.ctrl_we || cmd_i.ack_we))

endmodule

// File: sv/bank_mapper_with_line_irq_core.sv
// Top level of the bank mapper with line interrupt counter.
//
//   port group   dir  beat fields (low bit up)
//   s_axis       in   tuser: kind; tdata: address[15:0], data[23:16], cycles[31:24]
//   m_axis       out  tuser: map_valid; tdata: map_target[3:0], map_value[11:4],
//                     irq_fires[13:12], zero fill[15:14]
//   cfg          in   cfg_we_i / cfg_wdata_i: swap_address_lines
//
// A bus write, or a tick while the counter is disabled, is answered from ST_IDLE.
// A tick with the counter enabled enters ST_RUN, where the line unit retires one line
// per cycle until the sum of prescaler and cycles falls below LINE_CYCLES.
// Reset clears the control state at once (not the output data register); there is no clearing pass.
// While the output register holds an untaken beat, a finished item waits and
// no new input beat is accepted.
module bank_mapper_with_line_irq_core
  import bmlirq_pkg::*;
#(
  parameter int LINE_CYCLES = LINE_CYCLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address, data, cycles
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // map_target, map_value, irq_fires, zero fill
  output logic        m_axis_tuser    // map_valid
);

  seq_state_e   state_q, state_d;
  logic         swap_q;
  logic         m_valid_q, m_valid_d;
  logic [15:0]  m_data_q, m_data_d;
  logic         m_user_q, m_user_d;
  logic         out_free;
  logic         accept;
  logic         is_tick;
  logic         start;
  logic         wr;
  map_result_t  map;
  irq_cmd_t     cmd;
  line_status_t status;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (s_axis_tuser == KIND_TICK);
  assign wr            = accept && !is_tick;
  assign start         = accept && is_tick && status.enabled;

  bmlirq_decode u_decode (
    .wr_i      (wr),
    .swap_i    (swap_q),
    .address_i (s_axis_tdata[15:0]),
    .data_i    (s_axis_tdata[23:16]),
    .map_o     (map),
    .cmd_o     (cmd)
  );

  bmlirq_line_unit #(
    .LINE_CYCLES (LINE_CYCLES)
  ) u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .start_i  (start),
    .cycles_i (s_axis_tdata[31:24]),
    .take_i   ((state_q == ST_RUN) && out_free),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      swap_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        swap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
        end else if (accept) begin
          // Writes report their mapping; a tick with the counter off reports nothing.
          m_valid_d = 1'b1;
          m_user_d  = map.valid;
          m_data_d  = {2'b00, 2'b00, map.value, map.target};
        end
      end
      ST_RUN: begin
        if (status.done && out_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
          m_user_d  = 1'b0;
          m_data_d  = {2'b00, status.fires, 8'h00, 4'h0};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: bench/bank_mapper_result_checker.sv
// Result checker for the bank mapper: predicts every output beat and compares it.
module bank_mapper_result_checker
  import bmlirq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address, data, cycles
  input  logic        s_axis_tuser,   // kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // map_target, map_value, irq_fires, zero fill
  input  logic        m_axis_tuser,   // map_valid
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       map_valid;
    logic [1:0] fill;
    logic [1:0] fires;
    logic [7:0] value;
    logic [3:0] target;
  } mapper_beat_t;

  // Shadow copy of the mapper's interrupt state and configuration.
  logic       swap_lines;
  logic [6:0] prescale;
  logic [7:0] line_count;
  logic [7:0] reload;
  logic       irq_on;
  logic       irq_on_after_ack;

  mapper_beat_t expected_beats[$];

  function automatic mapper_beat_t predict_mapper_beat(logic kind, logic [15:0] addr,
                                                       logic [7:0] wdata, logic [7:0] cycles);
    mapper_beat_t r;
    logic [15:0] a;
    logic [15:0] sel;
    int unsigned total;
    r = '0;
    if (kind == KIND_TICK) begin
      if (irq_on) begin
        total = prescale + cycles;
        while (total >= LINE_CYCLES_DEF) begin
          total -= LINE_CYCLES_DEF;
          if (line_count == 8'hFF) begin
            line_count = reload;
            if (r.fires != FIRES_MAX) r.fires = r.fires + 2'd1;
          end else begin
            line_count = line_count + 8'd1;
          end
        end
        prescale = total[6:0];
      end
    end else begin
      a = swap_lines ? {addr[15:2], addr[0], addr[1]} : addr;
      sel = a & ADDR_MASK;
      if (sel == ADDR_PRG16) begin
        r.map_valid = 1'b1;
        r.target = TGT_PRG16;
        r.value = wdata;
      end else if (sel == ADDR_PRG8) begin
        r.map_valid = 1'b1;
        r.target = TGT_PRG8;
        r.value = wdata;
      end else if (sel[15:2] == ADDR_CHR_LO[15:2]) begin
        r.map_valid = 1'b1;
        r.target = TGT_CHR_LO + {2'b00, sel[1:0]};
        r.value = wdata;
      end else if (sel[15:2] == ADDR_CHR_HI[15:2]) begin
        r.map_valid = 1'b1;
        r.target = TGT_CHR_HI + {2'b00, sel[1:0]};
        r.value = wdata;
      end else if (sel == ADDR_MIRROR) begin
        r.map_valid = 1'b1;
        r.target = TGT_MIRROR;
        case (wdata[3:0])
          MIRW_A: r.value = MIR_TWO_V;
          MIRW_B: r.value = MIR_TWO_H;
          MIRW_C: r.value = MIR_ONE_PG0;
          MIRW_D: r.value = MIR_ONE_PG1;
          default: r = '0;
        endcase
      end else if (sel == ADDR_LATCH) begin
        reload = wdata;
      end else if (sel == ADDR_CTRL) begin
        irq_on = wdata[1];
        irq_on_after_ack = wdata[0];
        if (wdata[1]) line_count = reload;
      end else if (sel == ADDR_ACK) begin
        irq_on = irq_on_after_ack;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mapper_beat_t want;
    mapper_beat_t got;
    if (!rst_ni) begin
      swap_lines = 1'b0;
      prescale = '0;
      line_count = '0;
      reload = '0;
      irq_on = 1'b0;
      irq_on_after_ack = 1'b0;
      expected_beats.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (cfg_we_i) swap_lines = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_beats.push_back(predict_mapper_beat(s_axis_tuser, s_axis_tdata[15:0],
                                                     s_axis_tdata[23:16],
                                                     s_axis_tdata[31:24]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected: valid=%0d tdata=%h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display("%0t: expected valid=%0d target=%0d value=%0d fires=%0d fill=%0d",
                     $time, want.map_valid, want.target, want.value, want.fires, want.fill);
            $display("%0t:   actual valid=%0d target=%0d value=%0d fires=%0d fill=%0d",
                     $time, got.map_valid, got.target, got.value, got.fires, got.fill);
            mismatches++;
          end
        end
      end
      outstanding = expected_beats.size();
    end
  end

endmodule

// File: bench/bank_mapper_with_line_irq_core_tb.sv
// Top of the bank mapper testbench: clock, reset, stimulus, stalls and verdict.
module bank_mapper_with_line_irq_core_tb
  import bmlirq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 500;
  localparam int HOLD_CYCLES = 300;
  // Well above the receiver hold-off, which is the longest quiet stretch.
  localparam int QUIET_LIMIT = 3000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit tx_calm = 1'b0;
  bit hold_rx_req = 1'b0;

  bank_mapper_with_line_irq_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bank_mapper_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  initial begin : result_drain
    int stall;
    bit rx_calm;
    rx_calm = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (hold_rx_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx_req = 1'b0;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_beat(logic kind, logic [15:0] addr, logic [7:0] wdata,
                           logic [7:0] cycles);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {cycles, wdata, addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Unused fields carry random values so that the block must ignore them.
  task automatic send_write(logic [15:0] addr, logic [7:0] wdata);
    send_beat(KIND_WRITE, addr, wdata, 8'($urandom));
  endtask

  task automatic send_tick(logic [7:0] cycles);
    send_beat(KIND_TICK, 16'($urandom), 8'($urandom), cycles);
  endtask

  // Swap setting changes only once the block has drained.
  task automatic set_swap(logic swap);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= swap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_item();
    int pick;
    logic [15:0] dont_care;
    logic [7:0] wdata;
    pick = $urandom_range(0, 99);
    dont_care = 16'($urandom) & 16'h0FFC;
    wdata = 8'($urandom);
    if (pick < 30) begin
      send_tick(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 20)) : 8'($urandom));
    end else if (pick < 55) begin
      case ($urandom_range(0, 4))
        0: send_write(ADDR_PRG16 | dont_care, wdata);
        1: send_write(ADDR_PRG8 | dont_care, wdata);
        2: send_write(ADDR_CHR_LO | dont_care | 16'($urandom_range(0, 3)), wdata);
        3: send_write(ADDR_CHR_HI | dont_care | 16'($urandom_range(0, 3)), wdata);
        default: begin
          if ($urandom_range(0, 3) != 0) wdata[3:0] = {2'($urandom), 2'b00};
          send_write(ADDR_MIRROR | dont_care, wdata);
        end
      endcase
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0: begin
          // Latch values near the top make overflows frequent.
          if ($urandom_range(0, 1) == 0) wdata[7:4] = 4'hF;
          send_write(ADDR_LATCH | dont_care, wdata);
        end
        1: send_write(ADDR_CTRL | dont_care, wdata);
        default: send_write(ADDR_ACK | dont_care, wdata);
      endcase
    end else if (pick < 85) begin
      send_write(ADDR_MASK | dont_care, wdata);
    end else begin
      send_write(16'($urandom), wdata);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_swap(1'b0);

    send_write(ADDR_PRG16, 8'h00);
    send_write(ADDR_PRG8, 8'hFF);
    for (int k = 0; k < 4; k++) send_write(ADDR_CHR_LO | 16'(k), 8'h55 ^ 8'(k));
    for (int k = 0; k < 4; k++) send_write(ADDR_CHR_HI | 16'(k), 8'hAA ^ 8'(k));
    send_write(ADDR_MIRROR, {4'hF, MIRW_A});
    send_write(ADDR_MIRROR, {4'h0, MIRW_B});
    send_write(ADDR_MIRROR, {4'hA, MIRW_C});
    send_write(ADDR_MIRROR, {4'h5, MIRW_D});
    send_write(ADDR_MIRROR, 8'h05);
    send_write(ADDR_MASK, 8'h12);
    send_write(16'h9000, 8'h3C);
    // Counter enabled one below overflow: a full tick crosses two lines.
    send_write(ADDR_LATCH, 8'hFE);
    send_write(ADDR_CTRL, 8'h03);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_write(ADDR_ACK, 8'h00);
    send_write(ADDR_CTRL, 8'h00);
    send_tick(8'hFF);
    // Reloading to the top makes every line an overflow.
    send_write(ADDR_LATCH, 8'hFF);
    send_write(ADDR_CTRL, 8'h02);
    send_tick(8'hFF);
    send_tick(8'hFF);

    for (int phase = 0; phase < 4; phase++) begin
      set_swap(phase[0] ? 1'b0 : 1'b1);
      if (phase == 1) hold_rx_req = 1'b1;
      repeat (RANDOM_PER_PHASE) send_random_item();
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
